@@ sv/drop_oldest_frame_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the drop-oldest frame queue
// Short forms for clocked implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DROP_OLDEST_FRAME_QUEUE_ASSERT_SVH
`define DROP_OLDEST_FRAME_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define DOFQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DOFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dofq_pkg.sv @@
// ----------------------------------------------------------------------------
// dofq_pkg
// Types and codes shared by the drop-oldest frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dofq_pkg;

  localparam int unsigned ENTRY_W = 64;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_PUSH  = 3'd0;
  localparam action_t ACT_POP   = 3'd1;
  localparam action_t ACT_PEEK  = 3'd2;
  localparam action_t ACT_START = 3'd3;
  localparam action_t ACT_STOP  = 3'd4;
  localparam action_t ACT_CLEAR = 3'd5;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOT_RUN = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;

  localparam logic [7:0] REG_LOW_LATENCY = 8'd0;
  localparam logic [7:0] REG_FRAME_RATE  = 8'd1;

  localparam logic [7:0] DEFAULT_RATE = 8'd30;

  // Result metadata held while the entry read is in flight.
  typedef struct packed {
    status_t     status;
    logic        got;
    logic [8:0]  occupancy;
    logic [31:0] accepted;
    logic [31:0] dropped;
    logic [31:0] newest;
  } meta_t;

endpackage

`default_nettype wire

@@ sv/dofq_ram.sv @@
// ----------------------------------------------------------------------------
// dofq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dofq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/drop_oldest_frame_queue.sv @@
// ----------------------------------------------------------------------------
// drop_oldest_frame_queue
// Frame descriptor FIFO (handle + timestamp) that drops its oldest entry
// when a push finds it full. Supports pop, peek-newest, start, stop, clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_ready | action, frame_handle, frame_pts
//  out     | output    | out_valid/out_ready | status, handle, pts, occupancy,
//          |           |                     | accepted/dropped counts, newest
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
//  One request per cycle while the output is not stalled; each result passes
//  from the middle stage, which holds the registered read of the entry RAM,
//  to the output register.
//  All queue state (head, count, counters) updates in the cycle of acceptance.
//  Reset (rst_n low, synchronous) empties the queue, stops it and zeroes
//  counters; entry RAM contents are never cleared.
//  A stalled output holds its result; the middle stage holds the RAM read and
//  in_ready drops only when both stages are full and out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_oldest_frame_queue #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dofq_pkg::action_t  in_action,
  input  wire logic [31:0]        in_frame_handle,
  input  wire logic [31:0]        in_frame_pts,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output dofq_pkg::status_t       out_status,
  output logic [31:0]             out_handle,
  output logic [31:0]             out_pts,
  output logic [8:0]              out_occupancy,
  output logic [31:0]             out_accepted_count,
  output logic [31:0]             out_dropped_count,
  output logic [31:0]             out_newest_pts,

  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata
);

  import dofq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  // Fold a sum below twice the depth back into the ring.
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_V) ? (s - DEPTH_V) : s;
    return r[AW-1:0];
  endfunction

  // Queue state and configuration
  logic [AW-1:0] head_r,    head_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic          running_r, running_nxt;
  logic [31:0]   acc_r,     acc_nxt;
  logic [31:0]   drop_r,    drop_nxt;
  logic [31:0]   last_r,    last_nxt;
  logic          low_lat_r;
  logic [7:0]    rate_r;

  // Pipeline stages
  logic          s1_valid_r;
  meta_t         s1_r, s1_nxt;
  logic          out_valid_r;
  meta_t         out_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic          s1_adv, in_fire;

  // RAM ports
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Capacity, saturated at the depth
  logic [7:0]    cap_raw;
  logic [CW+7:0] cap_ext;
  logic [CW-1:0] cap;
  logic [CW-1:0] n_drop;

  logic [AW:0]   head_x, count_x;
  logic [AW-1:0] tail_addr, newest_addr;
  status_t       status;
  logic          got;

  always_comb begin
    cap_raw = low_lat_r ? 8'd1 : ((rate_r == 8'd0) ? DEFAULT_RATE : rate_r);
    cap_ext = (CW + 8)'(cap_raw);
    cap     = (cap_ext > (CW + 8)'(DEPTH)) ? CW'(DEPTH) : CW'(cap_raw);
  end

  // Advance the middle stage when the output register is free or drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign head_x      = (AW + 1)'(head_r);
  assign count_x     = (AW + 1)'(count_r);
  assign tail_addr   = wrap(head_x + count_x);
  assign newest_addr = wrap(head_x + count_x - (AW + 1)'(1));

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    running_nxt = running_r;
    acc_nxt     = acc_r;
    drop_nxt    = drop_r;
    last_nxt    = last_r;
    status      = ST_OK;
    got         = 1'b0;
    n_drop      = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_addr;
    ram_raddr   = newest_addr;

    if (in_fire) begin
      case (in_action)
        ACT_PUSH: begin
          if (!running_r) begin
            status = ST_NOT_RUN;
          end else begin
            // Drop from the head until the new frame fits.
            if (count_r >= cap) begin
              n_drop = count_r - cap + CW'(1);
            end
            head_nxt  = wrap(head_x + (AW + 1)'(n_drop));
            count_nxt = count_r - n_drop + CW'(1);
            drop_nxt  = drop_r + 32'(n_drop);
            acc_nxt   = acc_r + 32'd1;
            last_nxt  = in_frame_pts;
            ram_we    = 1'b1;
          end
        end
        ACT_POP: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            got    = 1'b1;
            ram_re = 1'b1;
            if (low_lat_r) begin
              // Discard all but the newest, then take it.
              ram_raddr = newest_addr;
              head_nxt  = tail_addr;
              count_nxt = '0;
              drop_nxt  = drop_r + 32'(count_r - CW'(1));
            end else begin
              ram_raddr = head_r;
              head_nxt  = wrap(head_x + (AW + 1)'(1));
              count_nxt = count_r - CW'(1);
            end
          end
        end
        ACT_PEEK: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            got    = 1'b1;
            ram_re = 1'b1;
          end
        end
        ACT_START: running_nxt = 1'b1;
        ACT_STOP:  running_nxt = 1'b0;
        ACT_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: ;
      endcase
    end

    s1_nxt.status    = status;
    s1_nxt.got       = got;
    s1_nxt.occupancy = 9'((CW + 9)'(count_nxt));
    s1_nxt.accepted  = acc_nxt;
    s1_nxt.dropped   = drop_nxt;
    s1_nxt.newest    = last_nxt;
  end

  // Update queue state; a write to either decoded register resets the queue instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      running_r <= 1'b0;
      acc_r     <= '0;
      drop_r    <= '0;
      last_r    <= '0;
      low_lat_r <= 1'b0;
      rate_r    <= '0;
    end else if (cfg_we && (cfg_index == REG_LOW_LATENCY || cfg_index == REG_FRAME_RATE)) begin
      if (cfg_index == REG_LOW_LATENCY) begin
        low_lat_r <= cfg_wdata[0];
      end else begin
        rate_r <= cfg_wdata;
      end
      head_r    <= '0;
      count_r   <= '0;
      running_r <= 1'b0;
      acc_r     <= '0;
      drop_r    <= '0;
      last_r    <= '0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      acc_r     <= acc_nxt;
      drop_r    <= drop_nxt;
      last_r    <= last_nxt;
    end
  end

  // Hold each request's metadata beside its RAM read, then register the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r       <= s1_r;
      out_entry_r <= s1_r.got ? ram_rdata : '0;
    end
  end

  dofq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_frame_handle, in_frame_pts}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_handle         = out_entry_r[63:32];
  assign out_pts            = out_entry_r[31:0];
  assign out_occupancy      = out_r.occupancy;
  assign out_accepted_count = out_r.accepted;
  assign out_dropped_count  = out_r.dropped;
  assign out_newest_pts     = out_r.newest;

`include "drop_oldest_frame_queue_assert.svh"

  `DOFQ_ASSERT_IMPL(a_count_le_cap, 1'b1, count_r <= cap, "entry count above capacity")
  `DOFQ_ASSERT_IMPL(a_head_in_ring, 1'b1, head_x < DEPTH_V, "head index outside ring")
  `DOFQ_ASSERT_NEXT(a_acc_quiet, !cfg_we && !(in_fire && in_action == ACT_PUSH), $stable(acc_r), "accepted count moved without a push")
  `DOFQ_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_r), "stalled middle stage lost its request")

endmodule

`default_nettype wire

@@ sim/tb_drop_oldest_frame_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drop_oldest_frame_queue
// Self-checking bench for the drop-oldest frame queue: directed corner
// requests, then random push/pop/peek traffic across several capacity
// settings, with random stalls on both channels and a mirror of the queue
// that predicts every result.
// ----------------------------------------------------------------------------

module tb_drop_oldest_frame_queue;
  import dofq_pkg::*;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 80;

  // Action codes the block must ignore.
  localparam action_t ACT_RSVD_6 = 3'd6;
  localparam action_t ACT_RSVD_7 = 3'd7;

  // Register indexes that decode to nothing.
  localparam logic [7:0] REG_SPARE     = 8'd2;
  localparam logic [7:0] REG_INDEX_TOP = 8'hFF;

  typedef struct {
    status_t     status;
    logic [31:0] handle;
    logic [31:0] pts;
    logic [8:0]  occupancy;
    logic [31:0] accepted;
    logic [31:0] dropped;
    logic [31:0] newest;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Queue mirror: own copy of the descriptor ring, counters and settings.
  // Each accepted request appends one expected result; each delivered result
  // is compared against the oldest one.
  // --------------------------------------------------------------------------
  class frame_queue_mirror;
    logic [63:0]   ring [SLOTS];
    int unsigned   head;
    int unsigned   fill;
    bit            running;
    logic [31:0]   accepted;
    logic [31:0]   dropped;
    logic [31:0]   newest;
    bit            low_lat;
    logic [7:0]    rate;
    frame_result_t expected_results [$];
    int unsigned   errors;

    function new();
      low_lat = 1'b0;
      rate    = 8'd0;
      errors  = 0;
      empty_queue();
    endfunction

    function void empty_queue();
      head     = 0;
      fill     = 0;
      running  = 1'b0;
      accepted = '0;
      dropped  = '0;
      newest   = '0;
    endfunction

    function int unsigned capacity_now();
      int unsigned cap;
      if (low_lat) cap = 1;
      else cap = (rate == 8'd0) ? int'(DEFAULT_RATE) : int'(rate);
      return (cap > SLOTS) ? SLOTS : cap;
    endfunction

    function void drop_oldest();
      head = (head + 1) % SLOTS;
      fill--;
      dropped++;
    endfunction

    function void apply_register(logic [7:0] index, logic [7:0] value);
      if (index == REG_LOW_LATENCY) low_lat = value[0];
      else if (index == REG_FRAME_RATE) rate = value;
      else return;
      empty_queue();
    endfunction

    function void note_request(action_t act, logic [31:0] handle, logic [31:0] pts);
      frame_result_t want;
      logic [63:0]   got;
      int unsigned   cap;
      want.status = ST_OK;
      got         = '0;
      case (act)
        ACT_PUSH: begin
          if (!running) begin
            want.status = ST_NOT_RUN;
          end else begin
            cap = capacity_now();
            while (fill >= cap && fill > 0) drop_oldest();
            ring[(head + fill) % SLOTS] = {handle, pts};
            fill++;
            accepted++;
            newest = pts;
          end
        end
        ACT_POP: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else begin
            // Low-latency pop keeps only the newest frame.
            if (low_lat) while (fill > 1) drop_oldest();
            got  = ring[head];
            head = (head + 1) % SLOTS;
            fill--;
          end
        end
        ACT_PEEK: begin
          if (fill == 0) want.status = ST_EMPTY;
          else got = ring[(head + fill - 1) % SLOTS];
        end
        ACT_START: running = 1'b1;
        ACT_STOP:  running = 1'b0;
        ACT_CLEAR: begin
          head = 0;
          fill = 0;
        end
        default: ;
      endcase
      want.handle    = got[63:32];
      want.pts       = got[31:0];
      want.occupancy = fill[8:0];
      want.accepted  = accepted;
      want.dropped   = dropped;
      want.newest    = newest;
      expected_results = {expected_results, want};
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, label, want, seen);
      end
    endfunction

    function void check_result(frame_result_t seen);
      frame_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting: status %0d handle 0x%0h",
                 $time, seen.status, seen.handle);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      compare_field("status",    32'(want.status),    32'(seen.status));
      compare_field("handle",    want.handle,         seen.handle);
      compare_field("pts",       want.pts,            seen.pts);
      compare_field("occupancy", 32'(want.occupancy), 32'(seen.occupancy));
      compare_field("accepted",  want.accepted,       seen.accepted);
      compare_field("dropped",   want.dropped,        seen.dropped);
      compare_field("newest",    want.newest,         seen.newest);
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  action_t     in_action       = ACT_PUSH;
  logic [31:0] in_frame_handle = '0;
  logic [31:0] in_frame_pts    = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  status_t     out_status;
  logic [31:0] out_handle;
  logic [31:0] out_pts;
  logic [8:0]  out_occupancy;
  logic [31:0] out_accepted_count;
  logic [31:0] out_dropped_count;
  logic [31:0] out_newest_pts;
  logic        cfg_we          = 1'b0;
  logic [7:0]  cfg_index       = '0;
  logic [7:0]  cfg_wdata       = '0;

  // Shared control between the request and result sides.
  bit          calm            = 1'b0;  // no idling on either side
  bit          long_hold_req   = 1'b0;  // ask the result side for one long stall
  int unsigned cycle_count     = 0;

  frame_queue_mirror mirror;

  drop_oldest_frame_queue #(
    .DEPTH(SLOTS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_frame_handle   (in_frame_handle),
    .in_frame_pts      (in_frame_pts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_pts           (out_pts),
    .out_occupancy     (out_occupancy),
    .out_accepted_count(out_accepted_count),
    .out_dropped_count (out_dropped_count),
    .out_newest_pts    (out_newest_pts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers. All drives are nonblocking at the rising edge;
  // handshake signals are sampled right after the edge, so they show the
  // values the block saw at that edge.
  // --------------------------------------------------------------------------

  // Offer one request, optionally after an idle burst, and hold it until taken.
  task automatic offer_request(input action_t act, input logic [31:0] handle,
                               input logic [31:0] pts);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_frame_handle <= handle;
    in_frame_pts    <= pts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_request(act, handle, pts);
  endtask

  // Drop valid and wait until every expected result has been delivered,
  // then let the two-stage pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_we after the last write.
  task automatic write_register(input logic [7:0] index, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    mirror.apply_register(index, value);
  endtask

  // Idle the block, then program both registers. Each write empties and
  // stops the queue, so the next phase opens with a start request.
  task automatic reconfigure(input logic [7:0] low_latency_val,
                             input logic [7:0] rate_val);
    drain_results();
    write_register(REG_LOW_LATENCY, low_latency_val);
    write_register(REG_FRAME_RATE, rate_val);
    cfg_we <= 1'b0;
  endtask

  function automatic action_t pick_action(int unsigned push_pct, bit with_control);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return ACT_PUSH;
    roll = $urandom_range(0, 99);
    // Fill phases keep to data traffic so the ring reaches capacity.
    if (!with_control) return (roll < 70) ? ACT_POP : ACT_PEEK;
    if (roll < 45) return ACT_POP;
    if (roll < 63) return ACT_PEEK;
    if (roll < 76) return ACT_START;
    if (roll < 85) return ACT_STOP;
    if (roll < 93) return ACT_CLEAR;
    return (roll < 96) ? ACT_RSVD_6 : ACT_RSVD_7;
  endfunction

  task automatic run_traffic(input int unsigned count, input int unsigned push_pct,
                             input bit with_control);
    action_t act;
    for (int unsigned n = 0; n < count; n++) begin
      act = pick_action(push_pct, with_control);
      offer_request(act, $urandom, $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every delivered result, stall in random bursts, and
  // serve one long stall on request so the block fills and backs up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned   hold_left;
    bit            long_hold_done;
    frame_result_t seen;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        seen.status    = out_status;
        seen.handle    = out_handle;
        seen.pts       = out_pts;
        seen.occupancy = out_occupancy;
        seen.accepted  = out_accepted_count;
        seen.dropped   = out_dropped_count;
        seen.newest    = out_newest_pts;
        mirror.check_result(seen);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (long_hold_req && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        hold_left = $urandom_range(1, 18);
      end
      out_ready <= rst_n && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    mirror = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings (capacity thirty), queue stopped and empty.
    offer_request(ACT_POP,    $urandom, $urandom);      // pop on empty queue
    offer_request(ACT_PEEK,   $urandom, $urandom);      // peek on empty queue
    offer_request(ACT_PUSH,   '1, '1);                  // push refused while stopped
    offer_request(ACT_RSVD_6, $urandom, $urandom);      // unused codes do nothing
    offer_request(ACT_RSVD_7, $urandom, $urandom);
    offer_request(ACT_START,  $urandom, $urandom);
    offer_request(ACT_PUSH,   '1, '1);                  // all-ones descriptor
    offer_request(ACT_PUSH,   '0, '0);                  // all-zeros descriptor
    offer_request(ACT_PUSH,   32'hA5A5_5A5A, 32'h5A5A_A5A5);
    offer_request(ACT_PEEK,   $urandom, $urandom);      // newest stays put
    offer_request(ACT_POP,    $urandom, $urandom);      // oldest comes out
    offer_request(ACT_CLEAR,  $urandom, $urandom);      // counters and run flag kept
    offer_request(ACT_POP,    $urandom, $urandom);
    offer_request(ACT_PUSH,   $urandom, $urandom);
    offer_request(ACT_PUSH,   $urandom, $urandom);
    offer_request(ACT_STOP,   $urandom, $urandom);
    offer_request(ACT_PUSH,   $urandom, $urandom);      // refused after stop
    offer_request(ACT_PEEK,   $urandom, $urandom);      // peek works while stopped
    offer_request(ACT_POP,    $urandom, $urandom);      // pop works while stopped
    offer_request(ACT_START,  $urandom, $urandom);

    // Low-latency mode; only bit 0 of the data counts.
    reconfigure(8'hFF, 8'd7);
    offer_request(ACT_START, $urandom, $urandom);
    run_traffic(25, 55, 1'b1);

    // Normal mode at capacity one; upper data bits must be ignored.
    reconfigure(8'hFE, 8'd1);
    offer_request(ACT_START, $urandom, $urandom);
    run_traffic(25, 55, 1'b1);

    // Rate zero falls back to thirty. Hold off the result side for a long
    // stretch so the pipe fills and in_ready drops.
    reconfigure(8'h00, 8'd0);
    long_hold_req <= 1'b1;
    offer_request(ACT_START, $urandom, $urandom);
    run_traffic(30, 65, 1'b1);

    // Writes to undecoded indexes must leave queue, counters and run flag alone.
    drain_results();
    write_register(REG_SPARE, 8'($urandom));
    write_register(REG_INDEX_TOP, 8'($urandom));
    cfg_we <= 1'b0;
    run_traffic(25, 65, 1'b1);

    // Largest rate: push hard enough to reach capacity (255 of 256 slots) and wrap past the ring's end.
    reconfigure(8'h00, 8'd255);
    offer_request(ACT_START, $urandom, $urandom);
    run_traffic(300, 95, 1'b0);

    // Closing stretch at a random rate with no idling on either side.
    reconfigure(8'h00, 8'($urandom_range(2, 40)));
    calm <= 1'b1;
    offer_request(ACT_START, $urandom, $urandom);
    run_traffic(25, 60, 1'b1);

    drain_results();
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
